FILE: src/bspg_pkg.sv
// Shared types, constants and verdict codes for the band steering probe gate.
package bspg_pkg;

   localparam int STATIONS = 64;
   localparam int STA_W    = $clog2(STATIONS);
   localparam int SLOT_W   = STA_W + 1;
   localparam int SLOTS    = 2 * STATIONS;

   localparam int TIME_W   = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLICY_ENABLED = 3'd0,
      CSR_PROBE_STEER_ON = 3'd1,
      CSR_PREF_BAND_MODE = 3'd2,
      CSR_PREF_RSSI_MIN  = 3'd3,
      CSR_SIGNAL_MARGIN  = 3'd4,
      CSR_DENY_PERIOD    = 3'd5,
      CSR_GRACE_PERIOD   = 3'd6,
      CSR_PREF_MAX_AGE   = 3'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      PREF_NONE = 2'd0,
      PREF_LOW  = 2'd1,
      PREF_HIGH = 2'd2,
      PREF_ALT  = 2'd3
   } pref_mode_type;

   typedef enum logic [2:0] {
      V_PASS          = 3'd0,
      V_NOT_ADMITTED  = 3'd1,
      V_GRACE         = 3'd2,
      V_PREF_UNUSABLE = 3'd3,
      V_CUR_STRONGER  = 3'd4,
      V_DENYING       = 3'd5,
      V_GAVE_UP       = 3'd6,
      V_SPARE         = 3'd7
   } verdict_type;

   typedef struct packed {
      logic [TIME_W-1:0] deny_origin;
      logic [TIME_W-1:0] grace_end;
   } entry_type;

   typedef struct packed {
      logic              early_hit;
      logic              early_allow;
      verdict_type       early_verdict;
      logic              pref_bad;
      logic              cur_stronger;
      logic [TIME_W-1:0] now;
   } ctx_type;

   typedef struct packed {
      logic        allow;
      verdict_type verdict;
      logic        write;
      entry_type   entry;
   } outcome_type;

endpackage

FILE: src/bspg_decide.sv
// Table part of the decision: grace window, deny timer and give-up handling.
module bspg_decide import bspg_pkg::*; (
   input  ctx_type           ctx,
   input  entry_type         cur_entry,
   input  logic [TIME_W-1:0] deny_period,
   input  logic [TIME_W-1:0] grace_period,
   output outcome_type       outcome
);

   logic [TIME_W-1:0] deny_origin_new;
   logic [TIME_W-1:0] deny_elapsed;

   assign deny_origin_new = (cur_entry.deny_origin == '0) ? ctx.now : cur_entry.deny_origin;
   assign deny_elapsed    = ctx.now - deny_origin_new;

   always_comb begin
      outcome.allow             = 1'b1;
      outcome.verdict           = V_PASS;
      outcome.write             = 1'b0;
      outcome.entry             = cur_entry;
      if (ctx.early_hit) begin
         outcome.allow   = ctx.early_allow;
         outcome.verdict = ctx.early_verdict;
      end else if (ctx.now < cur_entry.grace_end) begin
         outcome.verdict = V_GRACE;
      end else if (ctx.pref_bad) begin
         outcome.verdict           = V_PREF_UNUSABLE;
         outcome.write             = 1'b1;
         outcome.entry.deny_origin = '0;
      end else if (ctx.cur_stronger) begin
         outcome.verdict           = V_CUR_STRONGER;
         outcome.write             = 1'b1;
         outcome.entry.deny_origin = '0;
      end else if (deny_elapsed < deny_period) begin
         outcome.allow             = 1'b0;
         outcome.verdict           = V_DENYING;
         outcome.write             = 1'b1;
         outcome.entry.deny_origin = deny_origin_new;
      end else begin
         outcome.verdict           = V_GAVE_UP;
         outcome.write             = 1'b1;
         outcome.entry.deny_origin = '0;
         outcome.entry.grace_end   = ctx.now + grace_period;
      end
   end

endmodule

FILE: src/band_steer_probe_gate.sv
// Band steering probe gate: per-station, per-band deny and grace decisions.
//
// Requests arrive on the req_ channel (valid/ready) and each produces exactly
// one result transaction on the rsp_ channel: allow and a verdict code.
// Configuration is written through csr_we, csr_index and csr_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
// Writes take effect at once and have no read-back. A request is accepted in
// the idle state, which also reads the station's table entry; in the evaluation
// state the entry is evaluated, written back as needed and its result registered
// once the output register is free. No new request is taken until the result
// of the last one has been registered.
// The deny-start and allow-until times live in one 128-entry table with a
// valid flag per entry; reset clears the flags at once, so every entry reads
// as zero after reset and no clearing pass is needed.
// When the receiver stalls, the result waits in the output register and the
// block holds the next evaluated request until the register is free.
// Reset returns the registers to their defaults and drops any transaction.
module band_steer_probe_gate import bspg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [5:0]            req_station,
   input  logic                  req_request_band,
   input  logic                  req_bss_matches,
   input  logic                  req_admission_ok,
   input  logic                  req_steerable_request,
   input  logic [31:0]           req_now,
   input  logic                  req_pref_usable,
   input  logic [31:0]           req_pref_seen,
   input  logic signed [7:0]     req_pref_signal,
   input  logic                  req_cur_signal_valid,
   input  logic signed [7:0]     req_cur_signal,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_allow,
   output logic [2:0]            rsp_verdict,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EVAL = 2'b10
   } state_type;

   state_type          state_ff, state_in;

   logic               policy_enabled_ff;
   logic               probe_steer_on_ff;
   pref_mode_type      pref_mode_ff;
   logic signed [7:0]  pref_rssi_min_ff;
   logic [6:0]         signal_margin_ff;
   logic [TIME_W-1:0]  deny_period_ff;
   logic [TIME_W-1:0]  grace_period_ff;
   logic [TIME_W-1:0]  pref_max_age_ff;

   entry_type          tbl_ff [SLOTS];
   logic [SLOTS-1:0]   tbl_vld_ff;
   entry_type          rd_entry_ff;
   logic               rd_vld_ff;
   entry_type          cur_entry;

   ctx_type            ctx_ff, ctx_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   outcome_type        outcome;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_allow_ff;
   verdict_type        rsp_verdict_ff;

   logic               accept;
   logic               out_free;
   logic               finish;
   logic               tbl_we;
   logic               want_band;
   logic [TIME_W-1:0]  pref_age;
   logic signed [8:0]  sig_diff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_enabled_ff <= 1'b0;
         probe_steer_on_ff <= 1'b0;
         pref_mode_ff      <= PREF_NONE;
         pref_rssi_min_ff  <= -8'sd70;
         signal_margin_ff  <= 7'd8;
         deny_period_ff    <= '0;
         grace_period_ff   <= '0;
         pref_max_age_ff   <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_POLICY_ENABLED: policy_enabled_ff <= csr_wdata[0];
            CSR_PROBE_STEER_ON: probe_steer_on_ff <= csr_wdata[0];
            CSR_PREF_BAND_MODE: pref_mode_ff      <= pref_mode_type'(csr_wdata[1:0]);
            CSR_PREF_RSSI_MIN:  pref_rssi_min_ff  <= csr_wdata[7:0];
            CSR_SIGNAL_MARGIN:  signal_margin_ff  <= csr_wdata[6:0];
            CSR_DENY_PERIOD:    deny_period_ff    <= csr_wdata[TIME_W-1:0];
            CSR_GRACE_PERIOD:   grace_period_ff   <= csr_wdata[TIME_W-1:0];
            CSR_PREF_MAX_AGE:   pref_max_age_ff   <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == ST_EVAL) && out_free;
   assign tbl_we    = finish && outcome.write;

   // Checks that need only the request fields are settled in the accept cycle.
   assign want_band = (pref_mode_ff != PREF_LOW);
   assign pref_age  = req_now - req_pref_seen;
   assign sig_diff  = 9'(req_cur_signal) - 9'(req_pref_signal);
   assign slot_in   = {req_station[STA_W-1:0], req_request_band};

   always_comb begin
      ctx_in.now           = req_now;
      ctx_in.pref_bad      = !req_pref_usable || (pref_age > pref_max_age_ff)
                             || (req_pref_signal < pref_rssi_min_ff);
      ctx_in.cur_stronger  = req_cur_signal_valid
                             && (sig_diff >= $signed({2'b00, signal_margin_ff}));
      ctx_in.early_hit     = 1'b1;
      ctx_in.early_allow   = 1'b1;
      ctx_in.early_verdict = V_PASS;
      if (!policy_enabled_ff || !req_bss_matches) begin
         ctx_in.early_verdict = V_PASS;
      end else if (!req_admission_ok) begin
         ctx_in.early_allow   = 1'b0;
         ctx_in.early_verdict = V_NOT_ADMITTED;
      end else if (!req_steerable_request || !probe_steer_on_ff
                   || (pref_mode_ff == PREF_NONE)) begin
         ctx_in.early_verdict = V_PASS;
      end else if (req_request_band == want_band) begin
         ctx_in.early_verdict = V_PASS;
      end else begin
         ctx_in.early_hit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctx_ff  <= ctx_in;
         slot_ff <= slot_in;
      end
   end

   // Station table: read on acceptance, written back when the result is registered, if the verdict calls for it.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_entry_ff <= tbl_ff[slot_in];
      end
      if (tbl_we) begin
         tbl_ff[slot_ff] <= outcome.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (accept) begin
            rd_vld_ff <= tbl_vld_ff[slot_in];
         end
         if (tbl_we) begin
            tbl_vld_ff[slot_ff] <= 1'b1;
         end
      end
   end

   assign cur_entry = rd_vld_ff ? rd_entry_ff : '0;

   bspg_decide u_decide (
      .ctx          (ctx_ff),
      .cur_entry    (cur_entry),
      .deny_period  (deny_period_ff),
      .grace_period (grace_period_ff),
      .outcome      (outcome)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) begin
            state_in = ST_EVAL;
         end
         ST_EVAL: if (out_free) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_allow_ff   <= outcome.allow;
         rsp_verdict_ff <= outcome.verdict;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_allow   = rsp_allow_ff;
   assign rsp_verdict = rsp_verdict_ff;

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EVAL))
      else $error("accepted transaction did not move to evaluation");

   a_write_in_eval: assert property (@(posedge clock) disable iff (reset)
      tbl_we |-> (state_ff == ST_EVAL) && !req_ready)
      else $error("table written outside evaluation");

   a_result_from_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EVAL))
      else $error("result appeared without an evaluated transaction");

   a_deny_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (((rsp_verdict_ff == V_DENYING)
                         || (rsp_verdict_ff == V_NOT_ADMITTED)) == !rsp_allow_ff))
      else $error("allow flag disagrees with verdict");

endmodule
